// ===== rtl/svm_pkg.sv =====
package svm_pkg;

    // converter resolution; scaling shifts follow from it
    localparam int unsigned ADC_BITS   = 12;
    localparam int unsigned MUL_W      = 10;
    localparam int unsigned TENTHS_W   = 10;
    localparam int unsigned MV_W       = 20;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned STEP_W     = 11;

    localparam logic [MUL_W-1:0]    SCALE_MUL   = 10'd543;
    localparam logic [TENTHS_W-1:0] MAIN_BIAS   = 10'd11;
    localparam logic [STEP_W-1:0]   AUX_BIAS    = 11'd21;
    localparam logic [6:0]          MV_PER_STEP = 7'd100;

    // register reset values
    localparam logic [ADC_BITS-1:0] CUT_LEVEL_RST       = 12'd500;
    localparam logic [COUNT_W-1:0]  DEBOUNCE_LIMIT_RST  = 8'd15;
    localparam logic [TENTHS_W-1:0] BAND_EDGE_RST       = 10'd160;
    localparam logic [TENTHS_W-1:0] LIMIT_LOW_BAND_RST  = 10'd100;
    localparam logic [TENTHS_W-1:0] LIMIT_HIGH_BAND_RST = 10'd170;
    localparam logic [ADC_BITS-1:0] AUX_OFFSET_RST      = 12'd70;

    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUT_LEVEL       = 3'd0,
        CFG_DEBOUNCE_LIMIT  = 3'd1,
        CFG_BAND_EDGE       = 3'd2,
        CFG_LIMIT_LOW_BAND  = 3'd3,
        CFG_LIMIT_HIGH_BAND = 3'd4,
        CFG_AUX_OFFSET      = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [ADC_BITS-1:0] main_raw;
        logic [ADC_BITS-1:0] aux1_raw;
        logic [ADC_BITS-1:0] aux2_raw;
    } in_t;

    typedef struct packed {
        logic [TENTHS_W-1:0]    main_tenths;
        logic signed [MV_W-1:0] aux1_millivolts;
        logic signed [MV_W-1:0] aux2_millivolts;
        logic                   on_battery;
        logic                   low_warn;
        logic                   cut_event;
        logic                   recover_event;
        logic                   warn_set_event;
        logic                   warn_clear_event;
        logic [TENTHS_W-1:0]    low_limit;
    } out_t;

    typedef struct packed {
        logic [ADC_BITS-1:0] cut_level;
        logic [COUNT_W-1:0]  debounce_limit;
        logic [TENTHS_W-1:0] band_edge;
        logic [TENTHS_W-1:0] limit_low_band;
        logic [TENTHS_W-1:0] limit_high_band;
        logic [ADC_BITS-1:0] aux_offset;
    } cfg_t;

    typedef struct packed {
        logic                on_battery;
        logic                low_warn;
        logic                cut_event;
        logic                recover_event;
        logic                warn_set_event;
        logic                warn_clear_event;
        logic [TENTHS_W-1:0] low_limit;
    } status_t;

    // captured sample, already scaled up to the per-step value
    typedef struct packed {
        logic [ADC_BITS-1:0]      main_raw;
        logic [TENTHS_W-1:0]      tenths;
        logic signed [STEP_W-1:0] aux1_step;
        logic signed [STEP_W-1:0] aux2_step;
    } stage_t;

endpackage

// ===== rtl/svm_aux_scale.sv =====
module svm_aux_scale
    import svm_pkg::*;
(
    input  logic [ADC_BITS-1:0]      raw,
    input  logic [ADC_BITS-1:0]      offset,
    output logic signed [STEP_W-1:0] step
);

    localparam int unsigned DIFF_W = ADC_BITS + 1;
    localparam int unsigned PROD_W = ADC_BITS + MUL_W + 1;
    localparam logic signed [PROD_W-1:0] MUL_S = PROD_W'(SCALE_MUL);

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] diff_ext;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] quot;

    assign diff     = $signed({1'b0, raw}) - $signed({1'b0, offset});
    assign diff_ext = {{(PROD_W-DIFF_W){diff[DIFF_W-1]}}, diff};
    assign prod     = diff_ext * MUL_S;
    // arithmetic shift gives the floor for negative products
    assign quot     = prod >>> ADC_BITS;
    assign step     = $signed(quot[STEP_W-1:0]) + $signed(AUX_BIAS);

endmodule

// ===== rtl/svm_supervisor.sv =====
module svm_supervisor
    import svm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [ADC_BITS-1:0] main_raw,
    input  logic [TENTHS_W-1:0] tenths,
    input  cfg_t                cfg,
    output status_t             status
);

    logic [COUNT_W-1:0]  cut_count_reg, cut_count_next;
    logic [COUNT_W-1:0]  low_count_reg, low_count_next;
    logic                battery_reg, battery_next;
    logic                warn_reg, warn_next;
    logic [TENTHS_W-1:0] limit_reg, limit_next;
    logic [COUNT_W-1:0]  cut_inc;
    logic [COUNT_W-1:0]  low_inc;
    logic [TENTHS_W-1:0] band_limit;

    assign cut_inc    = cut_count_reg + 1'b1;
    assign low_inc    = low_count_reg + 1'b1;
    assign band_limit = (tenths <= cfg.band_edge) ? cfg.limit_low_band : cfg.limit_high_band;

    always_comb
    begin
        cut_count_next = cut_count_reg;
        low_count_next = low_count_reg;
        battery_next   = battery_reg;
        warn_next      = warn_reg;
        limit_next     = limit_reg;
        status         = '0;

        if (main_raw < cfg.cut_level)
        begin
            cut_count_next = cut_inc;
            if (cut_inc > cfg.debounce_limit)
            begin
                cut_count_next = '0;
                low_count_next = '0;
                if (!battery_reg)
                begin
                    battery_next     = 1'b1;
                    status.cut_event = 1'b1;
                end
            end
        end
        else
        begin
            cut_count_next       = '0;
            status.recover_event = battery_reg;
            battery_next         = 1'b0;
            limit_next           = band_limit;
            if (tenths < band_limit)
            begin
                // an active warning holds the counter where it is
                if (!warn_reg)
                begin
                    low_count_next = low_inc;
                    if (low_inc > cfg.debounce_limit)
                    begin
                        low_count_next        = '0;
                        warn_next             = 1'b1;
                        status.warn_set_event = 1'b1;
                    end
                end
            end
            else
            begin
                status.warn_clear_event = warn_reg;
                low_count_next          = '0;
                warn_next               = 1'b0;
            end
        end

        status.on_battery = battery_next;
        status.low_warn   = warn_next;
        status.low_limit  = limit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_count_reg <= '0;
            low_count_reg <= '0;
            battery_reg   <= 1'b0;
            warn_reg      <= 1'b0;
            limit_reg     <= '0;
        end
        else if (advance)
        begin
            cut_count_reg <= cut_count_next;
            low_count_reg <= low_count_next;
            battery_reg   <= battery_next;
            warn_reg      <= warn_next;
            limit_reg     <= limit_next;
        end
    end

endmodule

// ===== rtl/supply_voltage_monitor.sv =====
// Supply voltage monitor: takes one beat of three ADC samples per clock while the output is
// not stalled and returns one beat of results per sample, in order. Each sample passes a
// capture register, where the main channel is scaled to tenths of a volt and the auxiliary
// channels to offset-corrected steps, and then a result register, where the steps become
// millivolts and the cut and low-voltage debouncers update. The capture register can still
// take one beat while a finished result waits under stall. Registers are written through
// the configuration channel, which is always ready; the user must write them only while no
// sample is in flight, as the block itself does not enforce this.
module supply_voltage_monitor
    import svm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_t                  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_t                 out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int unsigned MAIN_PROD_W = ADC_BITS + MUL_W;
    localparam logic signed [MV_W-1:0] MV_S = MV_W'(MV_PER_STEP);

    cfg_t    cfg_reg;
    stage_t  stage_reg, stage_next;
    logic    stage_valid_reg, stage_valid_next;
    logic    out_valid_reg, out_valid_next;
    out_t    out_data_reg, out_data_next;
    logic    in_accept;
    logic    advance;
    status_t status;

    logic [MAIN_PROD_W-1:0]   main_prod;
    logic signed [STEP_W-1:0] aux1_step;
    logic signed [STEP_W-1:0] aux2_step;
    logic signed [MV_W-1:0]   aux1_ext;
    logic signed [MV_W-1:0]   aux2_ext;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cut_level       <= CUT_LEVEL_RST;
            cfg_reg.debounce_limit  <= DEBOUNCE_LIMIT_RST;
            cfg_reg.band_edge       <= BAND_EDGE_RST;
            cfg_reg.limit_low_band  <= LIMIT_LOW_BAND_RST;
            cfg_reg.limit_high_band <= LIMIT_HIGH_BAND_RST;
            cfg_reg.aux_offset      <= AUX_OFFSET_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CUT_LEVEL:       cfg_reg.cut_level       <= cfg_data[ADC_BITS-1:0];
                CFG_DEBOUNCE_LIMIT:  cfg_reg.debounce_limit  <= cfg_data[COUNT_W-1:0];
                CFG_BAND_EDGE:       cfg_reg.band_edge       <= cfg_data[TENTHS_W-1:0];
                CFG_LIMIT_LOW_BAND:  cfg_reg.limit_low_band  <= cfg_data[TENTHS_W-1:0];
                CFG_LIMIT_HIGH_BAND: cfg_reg.limit_high_band <= cfg_data[TENTHS_W-1:0];
                CFG_AUX_OFFSET:      cfg_reg.aux_offset      <= cfg_data[ADC_BITS-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign advance   = stage_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall  = stage_valid_reg && out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // capture stage scaling
    assign main_prod = MAIN_PROD_W'(in_data.main_raw) * MAIN_PROD_W'(SCALE_MUL);

    svm_aux_scale u_aux1_scale (
        .raw    (in_data.aux1_raw),
        .offset (cfg_reg.aux_offset),
        .step   (aux1_step)
    );

    svm_aux_scale u_aux2_scale (
        .raw    (in_data.aux2_raw),
        .offset (cfg_reg.aux_offset),
        .step   (aux2_step)
    );

    always_comb
    begin
        stage_next.main_raw  = in_data.main_raw;
        stage_next.tenths    = main_prod[MAIN_PROD_W-1:ADC_BITS] + MAIN_BIAS;
        stage_next.aux1_step = aux1_step;
        stage_next.aux2_step = aux2_step;
    end

    svm_supervisor u_supervisor (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .main_raw (stage_reg.main_raw),
        .tenths   (stage_reg.tenths),
        .cfg      (cfg_reg),
        .status   (status)
    );

    // result stage
    assign aux1_ext = {{(MV_W-STEP_W){stage_reg.aux1_step[STEP_W-1]}}, stage_reg.aux1_step};
    assign aux2_ext = {{(MV_W-STEP_W){stage_reg.aux2_step[STEP_W-1]}}, stage_reg.aux2_step};

    always_comb
    begin
        out_data_next.main_tenths      = stage_reg.tenths;
        out_data_next.aux1_millivolts  = aux1_ext * MV_S;
        out_data_next.aux2_millivolts  = aux2_ext * MV_S;
        out_data_next.on_battery       = status.on_battery;
        out_data_next.low_warn         = status.low_warn;
        out_data_next.cut_event        = status.cut_event;
        out_data_next.recover_event    = status.recover_event;
        out_data_next.warn_set_event   = status.warn_set_event;
        out_data_next.warn_clear_event = status.warn_clear_event;
        out_data_next.low_limit        = status.low_limit;
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_reg <= stage_next;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
